// ----- sv/mbrx_pkg.sv -----
// Shared types, codes and the CRC-16 step function of the request receiver.
package mbrx_pkg;

    localparam int WORD_W      = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_TX_DONE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_CRC   = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;
    localparam logic [1:0] ST_COUNT = 2'd3;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    localparam logic [7:0]  FC_READ_HOLD  = 8'h03;
    localparam logic [7:0]  FC_READ_INPUT = 8'h04;
    localparam logic [7:0]  FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0]  FC_WRITE_MULT = 8'h10;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    typedef enum logic [2:0] {
        PH_ADDR,
        PH_FUNC,
        PH_HEAD,
        PH_DATA,
        PH_BUSY,
        PH_IGNR
    } t_rx_phase;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HEAD,
        B_RDHI,
        B_RDLO,
        B_WORD
    } t_back_state;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        fc;
        logic [15:0]       p1;
        logic [15:0]       p2;
        logic [WORD_W-1:0] words;
    } t_job;

    function automatic logic [15:0] crc16_feed(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/modbus_rtu_request_receiver.sv -----
// A frame's header result goes from the job queue through the back part's job register to the
// output registers; each data word follows after two memory reads (high byte, then low byte).
// Throughput: one input item per cycle; input stalls while the two-entry job queue is full or
// while data words of a write-multiple frame are still being read from the frame memory.
// Reset is synchronous and active low: it clears the receive state, CRC, queue and output valid,
// and sets the slave address to 1; the frame memory is not cleared.
module modbus_rtu_request_receiver import mbrx_pkg::*; #(
    parameter int BUF_BYTES = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [1:0]  o_status,
    output logic [7:0]  o_function_code,
    output logic [15:0] o_first_param,
    output logic [15:0] o_second_param,
    output logic [15:0] o_word_register,
    output logic [15:0] o_word_value,
    output logic        o_last
);

    localparam int AW = $clog2(BUF_BYTES);

    logic          push, q_full, q_valid, pop, words_done;
    t_job          push_job, q_job;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    mbrx_front #(.BUF_BYTES(BUF_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_rx_byte    (i_rx_byte),
        .i_q_full     (q_full),
        .i_words_done (words_done),
        .o_push       (push),
        .o_job        (push_job),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata)
    );

    mbrx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    mbrx_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mbrx_back #(.BUF_BYTES(BUF_BYTES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_job         (q_job),
        .o_pop           (pop),
        .o_words_done    (words_done),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_status        (o_status),
        .o_function_code (o_function_code),
        .o_first_param   (o_first_param),
        .o_second_param  (o_second_param),
        .o_word_register (o_word_register),
        .o_word_value    (o_word_value),
        .o_last          (o_last)
    );

endmodule

// ----- sv/mbrx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mbrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mbrx_front.sv -----
// Front part: receive state machine, CRC, frame storage writes and job hand-off.
module mbrx_front import mbrx_pkg::*; #(
    parameter int BUF_BYTES = 80
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [7:0]                   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_operation,
    input  logic [7:0]                   i_rx_byte,
    input  logic                         i_q_full,
    input  logic                         i_words_done,
    output logic                         o_push,
    output t_job                         o_job,
    output logic                         o_ram_we,
    output logic [$clog2(BUF_BYTES)-1:0] o_ram_waddr,
    output logic [7:0]                   o_ram_wdata
);

    localparam int CW = $clog2(BUF_BYTES + 1);
    localparam int AW = $clog2(BUF_BYTES);

    t_rx_phase   r_phase, n_phase;
    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [CW-1:0] r_expected, n_expected;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_addr_reg;
    logic        r_words_pend;
    logic [7:0]  r_fc, r_p1_hi, r_p1_lo, r_p2_hi, r_p2_lo, r_cnt6;

    logic        accept;
    logic        cap_en;
    logic [CW-1:0] cap_idx;

    assign o_in_stall = i_q_full || r_words_pend;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ADDR;
            r_byte_count <= '0;
            r_expected   <= '0;
            r_crc        <= CRC_INIT;
            r_addr_reg   <= 8'd1;
            r_words_pend <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_expected   <= n_expected;
            r_crc        <= n_crc;
            if (i_cfg_we) begin
                r_addr_reg <= i_cfg_data;
            end
            if (o_push && (o_job.words != '0)) begin
                r_words_pend <= 1'b1;
            end else if (i_words_done) begin
                r_words_pend <= 1'b0;
            end
        end
    end

    // Header bytes are kept in registers so the back part needs the memory only for words.
    always_ff @(posedge i_clk) begin
        if (cap_en) begin
            case (cap_idx)
                CW'(1):  r_fc    <= i_rx_byte;
                CW'(2):  r_p1_hi <= i_rx_byte;
                CW'(3):  r_p1_lo <= i_rx_byte;
                CW'(4):  r_p2_hi <= i_rx_byte;
                CW'(5):  r_p2_lo <= i_rx_byte;
                CW'(6):  r_cnt6  <= i_rx_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [15:0]   crc_next;
        logic [CW-1:0] cnt_inc;
        logic [8:0]    want;
        logic [15:0]   p2;
        logic [17:0]   twice_p2;
        logic [1:0]    status;
        logic [6:0]    half_cnt;

        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_expected   = r_expected;
        n_crc        = r_crc;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_byte_count[AW-1:0];
        o_ram_wdata  = i_rx_byte;
        cap_en       = 1'b0;
        cap_idx      = r_byte_count;
        o_push       = 1'b0;

        crc_next = crc16_feed((r_phase == PH_ADDR) ? CRC_INIT : r_crc, i_rx_byte);
        cnt_inc  = r_byte_count + 1'b1;
        want     = 9'd9 + {1'b0, i_rx_byte};
        p2       = {r_p2_hi, r_p2_lo};
        twice_p2 = {1'b0, p2, 1'b0} + 18'd3;

        if (crc_next != 16'h0000) begin
            status = ST_CRC;
        end else if ((r_fc == FC_READ_HOLD) || (r_fc == FC_READ_INPUT)) begin
            status = ((p2 != 16'h0000) && (twice_p2 >= 18'(BUF_BYTES))) ? ST_COUNT : ST_OK;
        end else if ((r_fc == FC_WRITE_ONE) || (r_fc == FC_WRITE_MULT)) begin
            status = ST_OK;
        end else begin
            status = ST_UNSUP;
        end

        half_cnt = r_cnt6[7:1];
        o_job.status = status;
        o_job.fc     = r_fc;
        o_job.p1     = {r_p1_hi, r_p1_lo};
        o_job.p2     = p2;
        if ((status == ST_OK) && (r_fc == FC_WRITE_MULT)) begin
            o_job.words = (p2 < {9'd0, half_cnt}) ? p2[WORD_W-1:0] : half_cnt;
        end else begin
            o_job.words = '0;
        end

        if (accept) begin
            case (i_operation)
                OP_TIMEOUT: begin
                    if (r_phase != PH_BUSY) begin
                        n_phase = PH_ADDR;
                    end
                end
                OP_TX_DONE: n_phase = PH_ADDR;
                OP_BYTE: begin
                    unique case (r_phase)
                        PH_ADDR: begin
                            if ((i_rx_byte != 8'h00) && (i_rx_byte != r_addr_reg)) begin
                                n_phase = PH_IGNR;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = '0;
                                n_crc       = crc_next;
                                n_phase     = PH_FUNC;
                            end
                        end
                        PH_FUNC: begin
                            o_ram_we     = 1'b1;
                            o_ram_waddr  = AW'(1);
                            cap_en       = 1'b1;
                            cap_idx      = CW'(1);
                            n_crc        = crc_next;
                            n_byte_count = CW'(2);
                            if (i_rx_byte == FC_WRITE_MULT) begin
                                n_phase = PH_HEAD;
                            end else begin
                                n_expected = CW'(8);
                                n_phase    = PH_DATA;
                            end
                        end
                        PH_HEAD: begin
                            o_ram_we     = 1'b1;
                            cap_en       = 1'b1;
                            n_crc        = crc_next;
                            n_byte_count = cnt_inc;
                            if (cnt_inc >= CW'(7)) begin
                                if (want <= 9'(BUF_BYTES)) begin
                                    n_expected = want[CW-1:0];
                                    n_phase    = PH_DATA;
                                end else begin
                                    n_phase = PH_IGNR;
                                end
                            end
                        end
                        PH_DATA: begin
                            o_ram_we     = 1'b1;
                            cap_en       = 1'b1;
                            n_crc        = crc_next;
                            n_byte_count = cnt_inc;
                            if (cnt_inc >= r_expected) begin
                                o_push  = 1'b1;
                                n_phase = (status == ST_OK) ? PH_BUSY : PH_ADDR;
                            end
                        end
                        PH_BUSY, PH_IGNR: ;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- sv/mbrx_queue.sv -----
// Short job queue between the front and back parts.
module mbrx_queue import mbrx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- sv/mbrx_back.sv -----
// Back part: emits the header result and reads data words from the frame memory.
module mbrx_back import mbrx_pkg::*; #(
    parameter int BUF_BYTES = 80
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  t_job                         i_q_job,
    output logic                         o_pop,
    output logic                         o_words_done,
    output logic                         o_ram_re,
    output logic [$clog2(BUF_BYTES)-1:0] o_ram_raddr,
    input  logic [7:0]                   i_ram_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_kind,
    output logic [1:0]                   o_status,
    output logic [7:0]                   o_function_code,
    output logic [15:0]                  o_first_param,
    output logic [15:0]                  o_second_param,
    output logic [15:0]                  o_word_register,
    output logic [15:0]                  o_word_value,
    output logic                         o_last
);

    localparam int AW = $clog2(BUF_BYTES);

    t_back_state       r_state, n_state;
    t_job              r_job;
    logic [WORD_W-1:0] r_k;
    logic [7:0]        r_hi;
    logic              r_out_valid;
    logic              slot_free;
    logic              load_head, load_word, load_job, inc_k, cap_hi;
    logic [8:0]        addr_hi, addr_lo;

    logic              r_kind, r_last;
    logic [1:0]        r_status;
    logic [7:0]        r_fc;
    logic [15:0]       r_p1, r_p2, r_wreg, r_wval;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign addr_hi   = 9'd7 + {1'b0, r_k, 1'b0};
    assign addr_lo   = addr_hi + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_head || load_word) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        o_words_done = 1'b0;
        o_ram_re     = 1'b0;
        o_ram_raddr  = addr_hi[AW-1:0];
        load_head    = 1'b0;
        load_word    = 1'b0;
        load_job     = 1'b0;
        inc_k        = 1'b0;
        cap_hi       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop    = 1'b1;
                    load_job = 1'b1;
                    n_state  = B_HEAD;
                end
            end
            B_HEAD: begin
                if (slot_free) begin
                    load_head = 1'b1;
                    n_state   = (r_job.words == '0) ? B_IDLE : B_RDHI;
                end
            end
            B_RDHI: begin
                o_ram_re = 1'b1;
                n_state  = B_RDLO;
            end
            B_RDLO: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = addr_lo[AW-1:0];
                cap_hi      = 1'b1;
                n_state     = B_WORD;
            end
            B_WORD: begin
                if (slot_free) begin
                    load_word = 1'b1;
                    if (r_k + 1'b1 == r_job.words) begin
                        o_words_done = 1'b1;
                        n_state      = B_IDLE;
                    end else begin
                        inc_k   = 1'b1;
                        n_state = B_RDHI;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_job <= i_q_job;
            r_k   <= '0;
        end else if (inc_k) begin
            r_k <= r_k + 1'b1;
        end
        if (cap_hi) begin
            r_hi <= i_ram_rdata;
        end
        if (load_head) begin
            r_kind   <= KIND_HEADER;
            r_status <= r_job.status;
            r_fc     <= r_job.fc;
            r_p1     <= r_job.p1;
            r_p2     <= r_job.p2;
            r_wreg   <= 16'h0000;
            r_wval   <= 16'h0000;
            r_last   <= (r_job.words == '0);
        end else if (load_word) begin
            r_kind   <= KIND_WORD;
            r_status <= ST_OK;
            r_fc     <= FC_WRITE_MULT;
            r_p1     <= 16'h0000;
            r_p2     <= 16'h0000;
            r_wreg   <= r_job.p1 + {{(16 - WORD_W){1'b0}}, r_k};
            r_wval   <= {r_hi, i_ram_rdata};
            r_last   <= (r_k + 1'b1 == r_job.words);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_status        = r_status;
    assign o_function_code = r_fc;
    assign o_first_param   = r_p1;
    assign o_second_param  = r_p2;
    assign o_word_register = r_wreg;
    assign o_word_value    = r_wval;
    assign o_last          = r_last;

endmodule
